[sv/wfpd_pkg.sv]
// Package for the PD wall-following drive: codes, program ROM and lookup tables.
package wfpd_pkg;

  // Configuration register indexes
  localparam logic [2:0] REG_TARGET_DISTANCE = 3'd0;
  localparam logic [2:0] REG_FORWARD_SPEED   = 3'd1;
  localparam logic [2:0] REG_GAIN_PROP       = 3'd2;
  localparam logic [2:0] REG_GAIN_DERIV      = 3'd3;
  localparam logic [2:0] REG_TURN_LIMIT      = 3'd4;
  localparam logic [2:0] REG_MAX_WHEEL       = 3'd5;
  localparam logic [2:0] REG_MIN_WHEEL       = 3'd6;

  // Wall status codes
  localparam logic [1:0] WS_FOLLOW    = 2'd0;
  localparam logic [1:0] WS_TOO_CLOSE = 2'd1;
  localparam logic [1:0] WS_NO_WALL   = 2'd2;

  // Sensor breakpoints: readings for 0, 1 and 2 inches, and the no-wall floor
  localparam logic [11:0] READ_TOP   = 12'd450;
  localparam logic [11:0] READ_FLOOR = 12'd4;
  localparam logic [8:0]  READ_HI [3] = '{9'd450, 9'd270, 9'd45};

  // ceil(2^24 / span) for spans 180, 225 and 41; exact for 16-bit dividends
  localparam logic [18:0] RECIP [3] = '{19'd93207, 19'd74566, 19'd409201};

  // Datapath operations, one per program step
  typedef enum logic [2:0] {
    OP_CLASS = 3'd0,
    OP_RECIP = 3'd1,
    OP_PROP  = 3'd2,
    OP_DERIV = 3'd3,
    OP_RATE  = 3'd4,
    OP_EMIT  = 3'd5
  } op_t;

  localparam int STEP_W = 3;
  localparam int STEPS  = 6;
  localparam logic [STEP_W-1:0] STEP_EMIT = 3'd5;

  // One control word
  typedef struct packed {
    op_t               op;
    logic              jmp;     // jump to target when the sample is special
    logic [STEP_W-1:0] target;
    logic              last;
  } ucode_t;

  localparam ucode_t PROGRAM [STEPS] = '{
    '{op: OP_CLASS, jmp: 1'b1, target: STEP_EMIT, last: 1'b0},
    '{op: OP_RECIP, jmp: 1'b0, target: 3'd0,      last: 1'b0},
    '{op: OP_PROP,  jmp: 1'b0, target: 3'd0,      last: 1'b0},
    '{op: OP_DERIV, jmp: 1'b0, target: 3'd0,      last: 1'b0},
    '{op: OP_RATE,  jmp: 1'b0, target: 3'd0,      last: 1'b0},
    '{op: OP_EMIT,  jmp: 1'b0, target: 3'd0,      last: 1'b1}
  };

endpackage

[sv/wfpd_seq.sv]
// Microcode sequencer: step counter, program ROM and conditional jump.
module wfpd_seq (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic            special,
  input  logic            stall,
  output wfpd_pkg::ucode_t ctrl,
  output logic            busy
);
  import wfpd_pkg::*;

  logic [STEP_W-1:0] step;

  // Current control word
  assign ctrl = PROGRAM[step];

  // Step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else if (!busy) begin
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end
    end else if (!stall) begin
      if (ctrl.last) begin
        busy <= 1'b0;
      end else if (ctrl.jmp && special) begin
        step <= ctrl.target;
      end else begin
        step <= step + 1'b1;
      end
    end
  end

endmodule

[sv/wall_follow_pd_drive.sv]
// Top level of the PD wall-following drive: registers, datapath and handshakes.
//
//  channel  | direction | handshake             | payload
//  ---------+-----------+-----------------------+---------------------------------------
//  cfg      | in        | cfg_valid / cfg_ready | cfg_index, cfg_data
//  in       | in        | in_valid / in_ready   | wall_reading, restart
//  out      | out       | out_valid / out_ready | left_speed, right_speed, wall_distance,
//           |           |                       | wall_state, speed_clamped
//
// One sample at a time: six program steps when following (classify, reciprocal
// multiply, two gain multiplies on the one shared multiplier, rate clamp, wheel
// mix), two when too close or no wall.
// Reset sets the registers to their defaults and clears the stored error.
// A result waiting on out_ready holds the program at its last step only.
// cfg_ready is always high.
module wall_follow_pd_drive (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [2:0]        cfg_index,
  input  logic [12:0]       cfg_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [11:0]       wall_reading,
  input  logic              restart,
  output logic              out_valid,
  input  logic              out_ready,
  output logic signed [9:0] left_speed,
  output logic signed [9:0] right_speed,
  output logic [9:0]        wall_distance,
  output logic [1:0]        wall_state,
  output logic              speed_clamped
);
  import wfpd_pkg::*;

  logic [9:0]        target_distance;
  logic [8:0]        forward_speed;
  logic [11:0]       gain_prop;
  logic [11:0]       gain_deriv;
  logic [12:0]       turn_limit;
  logic signed [9:0] max_wheel_speed;
  logic signed [9:0] min_wheel_speed;

  ucode_t ctrl;
  logic   busy, stall, special, fire, accept;

  logic [11:0]        sig_r;
  logic               restart_r;
  logic [1:0]         seg_r, wstate_r;
  logic [15:0]        x_r;
  logic [9:0]         dist_r;
  logic signed [25:0] acc;
  logic signed [13:0] rate_r;
  logic signed [10:0] prev_error;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_distance <= 10'd256;
      forward_speed   <= 9'd150;
      gain_prop       <= 12'd51;
      gain_deriv      <= 12'd512;
      turn_limit      <= 13'd2145;
      max_wheel_speed <= 10'sd500;
      min_wheel_speed <= -10'sd500;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_TARGET_DISTANCE: target_distance <= cfg_data[9:0];
        REG_FORWARD_SPEED:   forward_speed   <= cfg_data[8:0];
        REG_GAIN_PROP:       gain_prop       <= cfg_data[11:0];
        REG_GAIN_DERIV:      gain_deriv      <= cfg_data[11:0];
        REG_TURN_LIMIT:      turn_limit      <= cfg_data[12:0];
        REG_MAX_WHEEL:       max_wheel_speed <= $signed(cfg_data[9:0]);
        REG_MIN_WHEEL:       min_wheel_speed <= $signed(cfg_data[9:0]);
        default: ;
      endcase
    end
  end

  // Input capture and sequencer
  assign in_ready = !busy;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (accept) begin
      sig_r     <= wall_reading;
      restart_r <= restart;
    end
  end

  assign stall = busy && (ctrl.op == OP_EMIT) && out_valid && !out_ready;
  assign fire  = busy && !stall;

  wfpd_seq u_seq (
    .clk     (clk),
    .rst     (rst),
    .start   (accept),
    .special (special),
    .stall   (stall),
    .ctrl    (ctrl),
    .busy    (busy)
  );

  // Classification and segment pick
  logic [1:0] cls_state, seg_sel;
  logic [8:0] diff;

  always_comb begin
    if (sig_r >= READ_TOP) begin
      cls_state = WS_TOO_CLOSE;
    end else if (sig_r <= READ_FLOOR) begin
      cls_state = WS_NO_WALL;
    end else begin
      cls_state = WS_FOLLOW;
    end
    if (sig_r <= {3'b0, READ_HI[2]}) begin
      seg_sel = 2'd2;
    end else if (sig_r <= {3'b0, READ_HI[1]}) begin
      seg_sel = 2'd1;
    end else begin
      seg_sel = 2'd0;
    end
    diff = READ_HI[seg_sel] - sig_r[8:0];
  end

  assign special = (cls_state != WS_FOLLOW);

  // Error terms
  logic signed [10:0] e;
  logic signed [11:0] d;

  assign e = $signed({1'b0, dist_r} - {1'b0, target_distance});
  assign d = $signed({e[10], e}) - $signed({prev_error[10], prev_error});

  // Shared multiplier
  logic signed [16:0] mul_a;
  logic signed [19:0] mul_b;
  logic signed [36:0] mul_p;

  always_comb begin
    case (ctrl.op)
      OP_RECIP: begin
        mul_a = $signed({1'b0, x_r});
        mul_b = $signed({1'b0, RECIP[seg_r]});
      end
      OP_PROP: begin
        mul_a = $signed({{6{e[10]}}, e});
        mul_b = $signed({8'b0, gain_prop});
      end
      OP_DERIV: begin
        mul_a = $signed({{5{d[11]}}, d});
        mul_b = $signed({8'b0, gain_deriv});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Rate: floor((8 - sum) / 16), clamped to the turn limit
  logic signed [26:0] rate_t;
  logic signed [22:0] rate_q, lim_pos, lim_neg, rate_c;

  always_comb begin
    rate_t  = 27'sd8 - $signed({acc[25], acc});
    rate_q  = rate_t[26:4];
    lim_pos = $signed({10'b0, turn_limit});
    lim_neg = -lim_pos;
    if (rate_q > lim_pos) begin
      rate_c = lim_pos;
    end else if (rate_q < lim_neg) begin
      rate_c = lim_neg;
    end else begin
      rate_c = rate_q;
    end
  end

  // Wheel mix: forward speed plus or minus 129 * rate / 4096, toward zero
  function automatic logic signed [10:0] div4096_tz(input logic signed [22:0] v);
    logic signed [22:0] adj;
    adj = v + (v[22] ? 23'sd4095 : 23'sd0);
    return adj[22:12];
  endfunction

  logic signed [21:0] delta;
  logic signed [22:0] base, sum_r, sum_l;
  logic signed [10:0] v_r, v_l, mx, mn;
  logic signed [9:0]  right_c, left_c;
  logic               hit;

  always_comb begin
    delta = $signed({rate_r[13], rate_r, 7'b0}) + $signed({{8{rate_r[13]}}, rate_r});
    base  = $signed({2'b0, forward_speed, 12'b0});
    sum_r = base + $signed({delta[21], delta});
    sum_l = base - $signed({delta[21], delta});
    v_r   = div4096_tz(sum_r);
    v_l   = div4096_tz(sum_l);
    mx    = $signed({max_wheel_speed[9], max_wheel_speed});
    mn    = $signed({min_wheel_speed[9], min_wheel_speed});
    hit   = 1'b0;
    // upper test first, then lower, as for crossed limits
    if (v_r > mx) begin
      right_c = max_wheel_speed;
      hit     = 1'b1;
    end else if (v_r < mn) begin
      right_c = min_wheel_speed;
      hit     = 1'b1;
    end else begin
      right_c = v_r[9:0];
    end
    if (v_l > mx) begin
      left_c = max_wheel_speed;
      hit    = 1'b1;
    end else if (v_l < mn) begin
      left_c = min_wheel_speed;
      hit    = 1'b1;
    end else begin
      left_c = v_l[9:0];
    end
  end

  // Datapath registers, one operation per step
  always_ff @(posedge clk) begin
    if (fire) begin
      case (ctrl.op)
        OP_CLASS: begin
          wstate_r <= cls_state;
          seg_r    <= seg_sel;
          x_r      <= {diff[7:0], 8'b0};
        end
        OP_RECIP: dist_r <= {seg_r, mul_p[31:24]};
        OP_PROP:  acc    <= mul_p[25:0];
        OP_DERIV: acc    <= acc + mul_p[25:0];
        OP_RATE:  rate_r <= rate_c[13:0];
        default: ;
      endcase
    end
  end

  // Stored error
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_error <= '0;
    end else if (fire && (ctrl.op == OP_CLASS) && restart_r) begin
      prev_error <= '0;
    end else if (fire && (ctrl.op == OP_EMIT)) begin
      prev_error <= (wstate_r == WS_FOLLOW) ? e : 11'sd0;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (fire && (ctrl.op == OP_EMIT)) begin
      if (wstate_r == WS_FOLLOW) begin
        left_speed    <= left_c;
        right_speed   <= right_c;
        wall_distance <= dist_r;
        speed_clamped <= hit;
      end else begin
        left_speed    <= '0;
        right_speed   <= '0;
        wall_distance <= '0;
        speed_clamped <= 1'b0;
      end
      wall_state <= wstate_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire && (ctrl.op == OP_EMIT)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Checks
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> !in_ready)
    else $error("sequencer not busy after an accepted sample");

  a_special_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (wall_state != WS_FOLLOW) |->
      (left_speed == 10'sd0) && (right_speed == 10'sd0) && !speed_clamped
      && (wall_distance == 10'd0))
    else $error("special status with nonzero drive fields");

  a_special_clears_error: assert property (@(posedge clk) disable iff (rst)
    fire && (ctrl.op == OP_EMIT) && (wstate_r != WS_FOLLOW) |=> (prev_error == 11'sd0))
    else $error("stored error not cleared on special sample");

  a_result_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(busy) && ($past(ctrl.op) == OP_EMIT))
    else $error("result appeared outside the emit step");

endmodule
